// File: rtl/rrdc_pkg.sv
// Shared types and constants for the raw record deframe and check unit.
package rrdc_pkg;

   localparam int WORD_W   = 32;
   localparam int CHAN_W   = 10;
   localparam int STAMP_W  = 64;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;

   // Framing constants of the record format.
   localparam logic [WORD_W-1:0] START_WORD  = 32'd2048;
   localparam logic [CHAN_W:0]   SIZE_OFFSET = 11'd10;
   localparam logic [CHAN_W:0]   HDR_FTR_WORDS = 11'd18;

   // Word positions of the captured header fields.
   localparam logic [CHAN_W-1:0] POS_PACKET_ID = 10'd1;
   localparam logic [CHAN_W-1:0] POS_SIZE      = 10'd2;
   localparam logic [CHAN_W-1:0] POS_STAMP_HI  = 10'd3;
   localparam logic [CHAN_W-1:0] POS_STAMP_LO  = 10'd4;
   localparam logic [CHAN_W-1:0] POS_TTL       = 10'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_TOTAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_WORDS   = 1'b1;

   // Status codes, lowest failing check wins.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_XOR   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OLD_STAMP = 3'd4;

   // Result of one finished record, as classified by the front end.
   typedef struct packed {
      logic               id_ok;
      logic               size_ok;
      logic               xor_zero;
      logic               stamp_newer;
      logic [STAMP_W-1:0] stamp;
      logic [WORD_W-1:0]  ttl;
   } check_type;

   // Handshake between the queue and its neighbours.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_stat_type;

endpackage

// File: rtl/rrdc_front.sv
// Front end: record framing, header capture, XOR check and timestamp compare.
module rrdc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rrdc_pkg::CHAN_W-1:0]     channels_total,
   input  logic [rrdc_pkg::CHAN_W-1:0]     record_words,
   input  logic                            word_fire,
   input  logic [rrdc_pkg::WORD_W-1:0]     data_word,
   output logic                            check_push,
   output rrdc_pkg::check_type             check_item
);

   logic                          hunting_ff, hunting_in;
   logic [rrdc_pkg::CHAN_W-1:0]   pos_ff, pos_in;
   logic [rrdc_pkg::WORD_W-1:0]   xor_ff, xor_in;
   logic                          id_ok_ff, id_ok_in;
   logic                          size_ok_ff, size_ok_in;
   logic [rrdc_pkg::WORD_W-1:0]   stamp_hi_ff, stamp_hi_in;
   logic [rrdc_pkg::WORD_W-1:0]   stamp_lo_ff, stamp_lo_in;
   logic [rrdc_pkg::WORD_W-1:0]   ttl_ff, ttl_in;
   logic [rrdc_pkg::STAMP_W-1:0]  last_ts_ff, last_ts_in;

   logic [rrdc_pkg::CHAN_W-1:0]   eff_pos;
   logic [rrdc_pkg::WORD_W-1:0]   eff_xor;
   logic                          eff_id_ok, eff_size_ok;
   logic [rrdc_pkg::WORD_W-1:0]   eff_stamp_hi, eff_stamp_lo, eff_ttl;
   logic [rrdc_pkg::CHAN_W:0]     xor_span;
   logic [rrdc_pkg::CHAN_W:0]     size_expect;
   logic [rrdc_pkg::CHAN_W-1:0]   last_pos;
   logic                          active;
   logic                          is_last;
   logic                          rec_ok;
   logic [rrdc_pkg::WORD_W-1:0]   xor_nx;
   logic                          id_ok_nx, size_ok_nx;
   logic [rrdc_pkg::WORD_W-1:0]   stamp_hi_nx, stamp_lo_nx, ttl_nx;
   logic [rrdc_pkg::STAMP_W-1:0]  stamp_nx;
   logic                          stamp_newer;

   // While hunting, a start word opens a fresh record at position zero.
   assign active       = !hunting_ff || (data_word == rrdc_pkg::START_WORD);
   assign eff_pos      = hunting_ff ? '0 : pos_ff;
   assign eff_xor      = hunting_ff ? '0 : xor_ff;
   assign eff_id_ok    = hunting_ff ? 1'b0 : id_ok_ff;
   assign eff_size_ok  = hunting_ff ? 1'b0 : size_ok_ff;
   assign eff_stamp_hi = hunting_ff ? '0 : stamp_hi_ff;
   assign eff_stamp_lo = hunting_ff ? '0 : stamp_lo_ff;
   assign eff_ttl      = hunting_ff ? '0 : ttl_ff;

   // Record bounds from configuration; a length of zero behaves as one.
   assign xor_span    = {1'b0, channels_total} + rrdc_pkg::HDR_FTR_WORDS;
   assign size_expect = {1'b0, channels_total} + rrdc_pkg::SIZE_OFFSET;
   assign last_pos    = (record_words == '0) ? '0 : record_words - 1'b1;
   assign is_last     = (eff_pos >= last_pos);

   // Fold the current beat into the running record state.
   always_comb begin
      xor_nx      = eff_xor;
      id_ok_nx    = eff_id_ok;
      size_ok_nx  = eff_size_ok;
      stamp_hi_nx = eff_stamp_hi;
      stamp_lo_nx = eff_stamp_lo;
      ttl_nx      = eff_ttl;
      if ({1'b0, eff_pos} < xor_span) begin
         xor_nx = eff_xor ^ data_word;
      end
      case (eff_pos)
         rrdc_pkg::POS_PACKET_ID: id_ok_nx = (data_word == 32'd1);
         rrdc_pkg::POS_SIZE: begin
            size_ok_nx = (data_word == {{(rrdc_pkg::WORD_W-rrdc_pkg::CHAN_W-1){1'b0}},
                                        size_expect});
         end
         rrdc_pkg::POS_STAMP_HI: stamp_hi_nx = data_word;
         rrdc_pkg::POS_STAMP_LO: stamp_lo_nx = data_word;
         rrdc_pkg::POS_TTL:      ttl_nx      = data_word;
         default: ;
      endcase
   end

   assign stamp_nx    = {stamp_hi_nx, stamp_lo_nx};
   assign stamp_newer = (stamp_nx > last_ts_ff);
   assign rec_ok      = id_ok_nx && size_ok_nx && (xor_nx == '0) && stamp_newer;

   // A record's last beat hands its check flags to the queue.
   assign check_push             = word_fire && active && is_last;
   assign check_item.id_ok       = id_ok_nx;
   assign check_item.size_ok     = size_ok_nx;
   assign check_item.xor_zero    = (xor_nx == '0);
   assign check_item.stamp_newer = stamp_newer;
   assign check_item.stamp       = stamp_nx;
   assign check_item.ttl         = ttl_nx;

   // Next record state.
   always_comb begin
      hunting_in  = hunting_ff;
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      id_ok_in    = id_ok_ff;
      size_ok_in  = size_ok_ff;
      stamp_hi_in = stamp_hi_ff;
      stamp_lo_in = stamp_lo_ff;
      ttl_in      = ttl_ff;
      last_ts_in  = last_ts_ff;
      if (word_fire && active) begin
         if (is_last) begin
            // A good record is followed at once by the next; a bad one sends us hunting.
            hunting_in  = !rec_ok;
            pos_in      = '0;
            xor_in      = '0;
            id_ok_in    = 1'b0;
            size_ok_in  = 1'b0;
            stamp_hi_in = '0;
            stamp_lo_in = '0;
            ttl_in      = '0;
            if (rec_ok) begin
               last_ts_in = stamp_nx;
            end
         end else begin
            hunting_in  = 1'b0;
            pos_in      = eff_pos + 1'b1;
            xor_in      = xor_nx;
            id_ok_in    = id_ok_nx;
            size_ok_in  = size_ok_nx;
            stamp_hi_in = stamp_hi_nx;
            stamp_lo_in = stamp_lo_nx;
            ttl_in      = ttl_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff  <= 1'b1;
         pos_ff      <= '0;
         xor_ff      <= '0;
         id_ok_ff    <= 1'b0;
         size_ok_ff  <= 1'b0;
         stamp_hi_ff <= '0;
         stamp_lo_ff <= '0;
         ttl_ff      <= '0;
         last_ts_ff  <= '0;
      end else begin
         hunting_ff  <= hunting_in;
         pos_ff      <= pos_in;
         xor_ff      <= xor_in;
         id_ok_ff    <= id_ok_in;
         size_ok_ff  <= size_ok_in;
         stamp_hi_ff <= stamp_hi_in;
         stamp_lo_ff <= stamp_lo_in;
         ttl_ff      <= ttl_in;
         last_ts_ff  <= last_ts_in;
      end
   end

endmodule

// File: rtl/rrdc_queue.sv
// Small first-in first-out queue of record check results.
module rrdc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rrdc_pkg::queue_ctrl_type ctrl,
   input  rrdc_pkg::check_type      wr_item,
   output rrdc_pkg::queue_stat_type stat,
   output rrdc_pkg::check_type      rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   rrdc_pkg::check_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.valid = (count_ff != '0);
   assign do_push    = ctrl.push && !stat.full;
   assign do_pop     = ctrl.pop && stat.valid;
   assign rd_item    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: rtl/rrdc_back.sv
// Back end: status priority encoding and the registered result beat.
module rrdc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  rrdc_pkg::check_type               item,
   output logic                              item_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rrdc_pkg::STATUS_W-1:0]     status,
   output logic [rrdc_pkg::STAMP_W-1:0]      timestamp,
   output logic [rrdc_pkg::WORD_W-1:0]       ttl_value
);

   logic                              valid_ff, valid_in;
   logic [rrdc_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [rrdc_pkg::STAMP_W-1:0]      stamp_ff;
   logic [rrdc_pkg::WORD_W-1:0]       ttl_ff;
   logic [rrdc_pkg::STATUS_W-1:0]     status_code;

   // The lowest failing check gives the status.
   always_comb begin
      if (!item.id_ok) begin
         status_code = rrdc_pkg::STATUS_BAD_ID;
      end else if (!item.size_ok) begin
         status_code = rrdc_pkg::STATUS_BAD_SIZE;
      end else if (!item.xor_zero) begin
         status_code = rrdc_pkg::STATUS_BAD_XOR;
      end else if (!item.stamp_newer) begin
         status_code = rrdc_pkg::STATUS_OLD_STAMP;
      end else begin
         status_code = rrdc_pkg::STATUS_OK;
      end
   end

   // Load the output register whenever it is empty or being drained.
   assign item_pop = item_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      if (item_pop) begin
         valid_in  = 1'b1;
         status_in = status_code;
      end else if (rsp_tready) begin
         valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (item_pop) begin
         stamp_ff <= item.stamp;
         ttl_ff   <= item.ttl;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign status     = status_ff;
   assign timestamp  = stamp_ff;
   assign ttl_value  = ttl_ff;

endmodule

// File: rtl/raw_record_deframe_check_unit.sv
// Top level of the raw record deframe and check unit.
//
// The req_ stream carries one 32-bit record word per beat. The unit hunts for
// the start word, frames each record by its configured length, checks the
// packet id, size, XOR sum and timestamp order, and gives one beat on the rsp_
// stream at each record's last word: status, timestamp and TTL word.
// Words that are dropped while hunting and words inside a record give no beat.
// One word is accepted every cycle while the check queue has room. A record's
// result beat passes through the check queue and output register before it
// shows on rsp_. The front end decides a record in the cycle of its last word,
// so records may follow one another without gaps. When the receiver stalls,
// results wait in the queue (QUEUE_DEPTH entries) and the output register;
// req_tready falls only once the queue is full. Reset clears the framing state
// and the last timestamp, sets hunting, and restores channels_total to 128 and
// record_words to 146. Configuration must be written through csr_ while the
// unit is idle, one register per cycle; the unit itself does not enforce this.
module raw_record_deframe_check_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   // Record word stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // [31:0] data_word
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [103:0]                       rsp_tdata,   // [2:0] status,
                                                           // [66:3] timestamp,
                                                           // [98:67] ttl_value,
                                                           // [103:99] zero
   // Configuration writes.
   input  logic                               csr_we,
   input  logic [rrdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rrdc_pkg::CHAN_W-1:0]        csr_wdata
);

   logic [rrdc_pkg::CHAN_W-1:0]     channels_total_ff, channels_total_in;
   logic [rrdc_pkg::CHAN_W-1:0]     record_words_ff, record_words_in;
   logic                            word_fire;
   logic                            check_push;
   rrdc_pkg::check_type             check_item;
   rrdc_pkg::check_type             queue_item;
   rrdc_pkg::queue_ctrl_type        queue_ctrl;
   rrdc_pkg::queue_stat_type        queue_stat;
   logic                            item_pop;
   logic [rrdc_pkg::STATUS_W-1:0]   status;
   logic [rrdc_pkg::STAMP_W-1:0]    timestamp;
   logic [rrdc_pkg::WORD_W-1:0]     ttl_value;

   // Configuration registers.
   always_comb begin
      channels_total_in = channels_total_ff;
      record_words_in   = record_words_ff;
      if (csr_we) begin
         unique case (csr_index)
            rrdc_pkg::CSR_CHANNELS_TOTAL: channels_total_in = csr_wdata;
            rrdc_pkg::CSR_RECORD_WORDS:   record_words_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_total_ff <= 10'd128;
         record_words_ff   <= 10'd146;
      end else begin
         channels_total_ff <= channels_total_in;
         record_words_ff   <= record_words_in;
      end
   end

   // Words are taken while the check queue has room.
   assign req_tready = !queue_stat.full;
   assign word_fire  = req_tvalid && req_tready;

   rrdc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .channels_total (channels_total_ff),
      .record_words   (record_words_ff),
      .word_fire      (word_fire),
      .data_word      (req_tdata),
      .check_push     (check_push),
      .check_item     (check_item)
   );

   assign queue_ctrl.push = check_push;
   assign queue_ctrl.pop  = item_pop;

   rrdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (queue_ctrl),
      .wr_item (check_item),
      .stat    (queue_stat),
      .rd_item (queue_item)
   );

   rrdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_stat.valid),
      .item       (queue_item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .timestamp  (timestamp),
      .ttl_value  (ttl_value)
   );

   // Result beat packing, first field in the lowest bits.
   assign rsp_tdata = {5'b0, ttl_value, timestamp, status};

endmodule
